// ----- sv/sed_pkg.sv -----
// Shared types and constants of the skeleton endpoint detector.
package sed_pkg;

	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int PIX_W   = 8;
	localparam int CODE_W  = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int DIM_MIN = 3;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               inner;
		logic               last;
		logic               pix;
	} s1_info_t;

endpackage

// ----- sv/sed_ifs.sv -----
// Stream interfaces for the pixel input and the result output.
interface sed_pix_if;
	logic                         valid;
	logic                         ready;
	logic [sed_pkg::PIX_W-1:0]    pixel_value;
	logic                         first_of_frame;

	modport source (output valid, pixel_value, first_of_frame, input ready);
	modport sink (input valid, pixel_value, first_of_frame, output ready);
endinterface

interface sed_res_if;
	logic                         valid;
	logic                         ready;
	logic [sed_pkg::COORD_W-1:0]  end_x;
	logic [sed_pkg::COORD_W-1:0]  end_y;
	logic [sed_pkg::CODE_W-1:0]   neighbour_code;
	logic                         is_endpoint;
	logic                         frame_done;

	modport source (output valid, end_x, end_y, neighbour_code, is_endpoint, frame_done,
		input ready);
	modport sink (input valid, end_x, end_y, neighbour_code, is_endpoint, frame_done,
		output ready);
endinterface

// ----- sv/skeleton_endpoint_detector_top.sv -----
// Top level of the skeleton endpoint detector.
//
//  channel  dir  handshake       payload
//  pix      in   valid/ready     pixel_value[7:0], first_of_frame
//  res      out  valid/ready     end_x[11:0], end_y[11:0], neighbour_code[7:0],
//                                is_endpoint, frame_done
//  apb      in   psel/penable    paddr[2:0], pwdata[31:0], prdata[31:0]; 0 width, 4 height
//
// One pixel per clock unless the output stalls; a pixel's result is registered in the
// stage 1 register, then in the output register. Rate is set by the line store RAM (one
// read port, one write port): one read and one write-back per pixel, with same-entry
// overlap resolved by a one-deep forward register. A result waiting in the output
// register stalls the pipe only for the next pixel that also yields a result. Reset
// clears counters, window and valid flags; line store contents are not cleared.
module skeleton_endpoint_detector_top #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sed_pix_if.sink                     pix,
	sed_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sed_pkg::PADDR_W-1:0] paddr,
	input  logic [sed_pkg::PDATA_W-1:0] pwdata,
	output logic [sed_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW:0]         w_eff;
	logic [RW:0]         h_eff;
	logic                fire_s1;
	logic                valid_s1;
	sed_pkg::s1_info_t   info_s1;
	logic [CW-1:0]       addr_s1;
	logic                rd_en;
	logic [CW-1:0]       rd_addr;
	logic [1:0]          rd_data;
	logic                wr_en;
	logic [CW-1:0]       wr_addr;
	logic [1:0]          wr_data;

	sed_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.w_eff   (w_eff),
		.h_eff   (h_eff)
	);

	sed_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.fire_s1  (fire_s1),
		.valid_s1 (valid_s1),
		.info_s1  (info_s1),
		.addr_s1  (addr_s1),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr)
	);

	sed_ram #(
		.WIDTH (2),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sed_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.info_s1  (info_s1),
		.addr_s1  (addr_s1),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.fire_s1  (fire_s1),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.res      (res)
	);

endmodule

// ----- sv/sed_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sed_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/sed_cfg.sv -----
// APB register block: image width and height, clamped to the usable range.
module sed_cfg #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sed_pkg::PADDR_W-1:0]   paddr,
	input  logic [sed_pkg::PDATA_W-1:0]   pwdata,
	output logic [sed_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [$clog2(MAX_WIDTH):0]    w_eff,
	output logic [$clog2(MAX_HEIGHT):0]   h_eff
);

	localparam int WW = $clog2(MAX_WIDTH) + 1;
	localparam int HW = $clog2(MAX_HEIGHT) + 1;

	logic [sed_pkg::DIM_W-1:0] width_q;
	logic [sed_pkg::DIM_W-1:0] height_q;
	logic                      wr;
	logic [31:0]               wide_w;
	logic [31:0]               wide_h;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sed_pkg::WIDTH_RESET;
			height_q <= sed_pkg::HEIGHT_RESET;
		end else if (wr) begin
			if (paddr[2] == sed_pkg::REG_HEIGHT) begin
				height_q <= pwdata[sed_pkg::DIM_W-1:0];
			end else begin
				width_q <= pwdata[sed_pkg::DIM_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == sed_pkg::REG_HEIGHT) begin
			prdata = sed_pkg::PDATA_W'(height_q);
		end else begin
			prdata = sed_pkg::PDATA_W'(width_q);
		end
	end

	assign wide_w = 32'(width_q);
	assign wide_h = 32'(height_q);

	always_comb begin
		if (wide_w < 32'(sed_pkg::DIM_MIN)) begin
			w_eff = WW'(sed_pkg::DIM_MIN);
		end else if (wide_w > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(wide_w);
		end
	end

	always_comb begin
		if (wide_h < 32'(sed_pkg::DIM_MIN)) begin
			h_eff = HW'(sed_pkg::DIM_MIN);
		end else if (wide_h > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(wide_h);
		end
	end

endmodule

// ----- sv/sed_scan.sv -----
// Raster scan: column/row counters, line store read address, stage 1 register.
module sed_scan #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sed_pix_if.sink                       pix,
	input  logic [$clog2(MAX_WIDTH):0]    w_eff,
	input  logic [$clog2(MAX_HEIGHT):0]   h_eff,
	input  logic                          fire_s1,
	output logic                          valid_s1,
	output sed_pkg::s1_info_t             info_s1,
	output logic [$clog2(MAX_WIDTH)-1:0]  addr_s1,
	output logic                          rd_en,
	output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_base;
	logic [RW-1:0] row_base;
	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic          c_end;
	logic          r_end;
	logic          acc;

	assign pix.ready = !valid_s1 || fire_s1;
	assign acc       = pix.valid && pix.ready;

	assign col_base = pix.first_of_frame ? '0 : col_q;
	assign row_base = pix.first_of_frame ? '0 : row_q;
	assign c        = ({1'b0, col_base} >= w_eff) ? '0 : col_base;
	assign r        = ({1'b0, row_base} >= h_eff) ? '0 : row_base;
	assign c_end    = ({1'b0, c} == w_eff - 1'b1);
	assign r_end    = ({1'b0, r} == h_eff - 1'b1);

	assign rd_en   = acc;
	assign rd_addr = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
				if (c_end) begin
					col_q <= '0;
					row_q <= r_end ? '0 : r + 1'b1;
				end else begin
					col_q <= c + 1'b1;
					row_q <= r;
				end
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1       <= c;
			info_s1.x     <= sed_pkg::COORD_W'(c - CW'(1));
			info_s1.y     <= sed_pkg::COORD_W'(r - RW'(1));
			info_s1.inner <= (c >= CW'(2)) && (r >= RW'(2));
			info_s1.last  <= c_end && r_end;
			info_s1.pix   <= (pix.pixel_value == '0);
		end
	end

endmodule

// ----- sv/sed_window.sv -----
// Line store read-modify-write, 3x3 window, neighbour code and result register.
module sed_window #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  sed_pkg::s1_info_t             info_s1,
	input  logic [$clog2(MAX_WIDTH)-1:0]  addr_s1,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  logic [1:0]                    rd_data,
	output logic                          fire_s1,
	output logic                          wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
	output logic [1:0]                    wr_data,
	sed_res_if.source                     res
);

	logic [1:0]                    fwd_data_q;
	logic                          fwd_q;
	logic [1:0]                    col_now;
	logic [2:0]                    left_col;
	logic [2:0]                    mid_col;
	logic [2:0]                    right_col;
	logic [2:0]                    mid_q;
	logic [2:0]                    right_q;
	logic [sed_pkg::CODE_W-1:0]    code;
	logic                          endpoint;
	logic                          has_res;
	logic                          out_valid_q;
	logic [sed_pkg::COORD_W-1:0]   x_q;
	logic [sed_pkg::COORD_W-1:0]   y_q;
	logic [sed_pkg::CODE_W-1:0]    code_q;
	logic                          endp_q;
	logic                          done_q;

	// line store entry: bit 1 row above, bit 0 row middle
	assign col_now = fwd_q ? fwd_data_q : rd_data;

	assign left_col  = mid_q;
	assign mid_col   = right_q;
	assign right_col = {info_s1.pix, col_now[0], col_now[1]};

	// N, NW, W, SW, S, SE, E, NE
	assign code = {mid_col[0], left_col[0], left_col[1], left_col[2],
		mid_col[2], right_col[2], right_col[1], right_col[0]};

	assign endpoint = mid_col[1] && (code != '0) && ((code & (code - 1'b1)) == '0);
	assign has_res  = info_s1.inner && (endpoint || info_s1.last);
	assign fire_s1  = valid_s1 && (!has_res || !out_valid_q || res.ready);

	assign wr_en   = fire_s1;
	assign wr_addr = addr_s1;
	assign wr_data = {col_now[0], info_s1.pix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q   <= '0;
			right_q <= '0;
		end else if (fire_s1) begin
			mid_q   <= mid_col;
			right_q <= right_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && has_res) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_res) begin
			x_q    <= info_s1.x;
			y_q    <= info_s1.y;
			code_q <= code;
			endp_q <= endpoint;
			done_q <= info_s1.last;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.end_x          = x_q;
	assign res.end_y          = y_q;
	assign res.neighbour_code = code_q;
	assign res.is_endpoint    = endp_q;
	assign res.frame_done     = done_q;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the skeleton endpoint detector: directed frames, then random frames, then edge sizes.
module testbench;

	localparam int MAX_W        = 4096;
	localparam int MAX_H        = 4096;
	localparam int RANDOM_ITEMS = 1060;
	localparam int EDGE_ITEMS   = 40;
	localparam int SETTLE       = 8;
	localparam int STALL_LIMIT  = 3000;
	localparam int LONG_HOLD    = 400;

	typedef struct packed {
		logic [sed_pkg::COORD_W-1:0] x;
		logic [sed_pkg::COORD_W-1:0] y;
		logic [sed_pkg::CODE_W-1:0]  code;
		logic                        line_end;
		logic                        frame_done;
	} endpoint_rec_t;

	typedef struct packed {
		logic [sed_pkg::PIX_W-1:0] value;
		logic                      first;
		logic                      has_res;
		endpoint_rec_t             want;
	} pixel_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [sed_pkg::PADDR_W-1:0] paddr;
	logic [sed_pkg::PDATA_W-1:0] pwdata;
	logic [sed_pkg::PDATA_W-1:0] prdata;
	logic pready;

	sed_pix_if pix_ch();
	sed_res_if res_ch();

	skeleton_endpoint_detector_top #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// three 3x3 frames; the centre (1,1) is reported on the last pixel of each
	pixel_row_t directed_px [27] = '{
		'{8'd255, 1'b1, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd1,   1'b0, 1'b0, '0},
		'{8'd128, 1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd2,   1'b0, 1'b0, '0},
		'{8'd64,  1'b0, 1'b0, '0},
		'{8'd4,   1'b0, 1'b0, '0},
		'{8'd255, 1'b0, 1'b1, '{12'd1, 12'd1, 8'd128, 1'b1, 1'b1}},
		// counters wrap into the next frame with no frame start mark
		'{8'd8,   1'b0, 1'b0, '0},
		'{8'd16,  1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd32,  1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd127, 1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd254, 1'b0, 1'b0, '0},
		'{8'd1,   1'b0, 1'b1, '{12'd1, 12'd1, 8'd17, 1'b0, 1'b1}},
		'{8'd0,   1'b1, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd255, 1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b1, '{12'd1, 12'd1, 8'd255, 1'b0, 1'b1}}
	};

	endpoint_rec_t expected [$];
	int errors = 0;
	int results_seen = 0;
	int pixels_fed = 0;
	int send_calm = 0;
	int take_calm = 0;

	// window model state
	logic [sed_pkg::DIM_W-1:0] cfg_width  = sed_pkg::WIDTH_RESET;
	logic [sed_pkg::DIM_W-1:0] cfg_height = sed_pkg::HEIGHT_RESET;
	bit occ_above [MAX_W];
	bit occ_mid [MAX_W];
	logic [8:0] win = '0;
	int unsigned col_at = 0;
	int unsigned row_at = 0;

	function automatic int unsigned clamp_dim(input logic [sed_pkg::DIM_W-1:0] v,
		input int unsigned hi);
		if (v < sed_pkg::DIM_MIN)
			return sed_pkg::DIM_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic bit window_step(input logic [sed_pkg::PIX_W-1:0] value, input logic first,
		output endpoint_rec_t rec);
		int unsigned w, h, c, r;
		logic occ, above, mid, last_px, line_end;
		logic [sed_pkg::CODE_W-1:0] code;
		w = clamp_dim(cfg_width, MAX_W);
		h = clamp_dim(cfg_height, MAX_H);
		occ = (value == '0);
		if (first) begin
			col_at = 0;
			row_at = 0;
		end
		if (col_at >= w)
			col_at = 0;
		if (row_at >= h)
			row_at = 0;
		c = col_at;
		r = row_at;
		above = occ_above[c];
		mid = occ_mid[c];
		occ_above[c] = mid;
		occ_mid[c] = occ;
		win = {occ, mid, above, win[8:3]};
		// N NW W SW S SE E NE, MSB first
		code = {win[3], win[0], win[1], win[2], win[5], win[8], win[7], win[6]};
		line_end = win[4] && ($countones(code) == 1);
		last_px = (c == w - 1) && (r == h - 1);
		rec.x = sed_pkg::COORD_W'(c - 1);
		rec.y = sed_pkg::COORD_W'(r - 1);
		rec.code = code;
		rec.line_end = line_end;
		rec.frame_done = last_px;
		if (c >= w - 1) begin
			col_at = 0;
			row_at = (r >= h - 1) ? 0 : r + 1;
		end else begin
			col_at = c + 1;
		end
		return (c >= 2) && (r >= 2) && (line_end || last_px);
	endfunction

	function automatic string fmt_rec(input endpoint_rec_t rec);
		return $sformatf("x=%0d y=%0d code=%0d end=%0b done=%0b",
			rec.x, rec.y, rec.code, rec.line_end, rec.frame_done);
	endfunction

	function automatic void note_error(input string msg);
		if (errors < 10)
			$display("ERROR: %s", msg);
		errors++;
	endfunction

	function automatic int idle_len(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 999);
		if (roll < 10) begin
			calm = $urandom_range(20, 120);
			return 0;
		end
		if (roll < 550)
			return 0;
		if (roll < 900)
			return $urandom_range(1, 3);
		if (roll < 985)
			return $urandom_range(4, 15);
		return $urandom_range(16, 80);
	endfunction

	function automatic logic [sed_pkg::DIM_W-1:0] pick_dim(input int common_hi, input int rare_hi);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return sed_pkg::DIM_W'($urandom_range(0, 2));
		if (roll < 80)
			return sed_pkg::DIM_W'($urandom_range(3, common_hi));
		return sed_pkg::DIM_W'($urandom_range(3, rare_hi));
	endfunction

	task automatic apb_write(input logic idx, input logic [sed_pkg::DIM_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= sed_pkg::PDATA_W'(data);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic idx, input logic [sed_pkg::DIM_W-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[sed_pkg::DIM_W-1:0] !== want)
			note_error($sformatf("register %0d read: expected %0d, got %0d",
				idx, want, prdata[sed_pkg::DIM_W-1:0]));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// dimensions change only with the block drained; the next pixel then starts a frame
	task automatic set_dims(input logic [sed_pkg::DIM_W-1:0] w,
		input logic [sed_pkg::DIM_W-1:0] h);
		pix_ch.valid <= 1'b0;
		while (expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
		apb_write(sed_pkg::REG_WIDTH, w);
		apb_write(sed_pkg::REG_HEIGHT, h);
		apb_read(sed_pkg::REG_WIDTH, w);
		apb_read(sed_pkg::REG_HEIGHT, h);
		cfg_width = w;
		cfg_height = h;
	endtask

	task automatic send_pixel(input logic [sed_pkg::PIX_W-1:0] value, input logic first,
		output bit has_res, output endpoint_rec_t rec);
		int gap;
		gap = idle_len(send_calm);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_value <= value;
		pix_ch.first_of_frame <= first;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		has_res = window_step(value, first, rec);
	endtask

	task automatic run_phase(input logic [sed_pkg::DIM_W-1:0] w_reg,
		input logic [sed_pkg::DIM_W-1:0] h_reg, input int frames, input int density,
		input bit cut_short, input int noise, input int limit);
		int area, total, n;
		logic first;
		logic [sed_pkg::PIX_W-1:0] value;
		bit has_res;
		endpoint_rec_t rec;
		area = clamp_dim(w_reg, MAX_W) * clamp_dim(h_reg, MAX_H);
		set_dims(w_reg, h_reg);
		total = frames * area;
		if (cut_short)
			total = $urandom_range(1, total);
		if (total > limit)
			total = limit;
		for (n = 0; n < total; n++) begin
			first = (n == 0) || ((n % area == 0) && ($urandom_range(0, 1) == 1));
			if (noise > 0 && $urandom_range(1, noise) == 1)
				first = 1'b1;
			value = ($urandom_range(1, density) == 1) ? '0
				: sed_pkg::PIX_W'($urandom_range(1, 255));
			send_pixel(value, first, has_res, rec);
			if (has_res)
				expected.insert(expected.size(), rec);
			pixels_fed++;
		end
	endtask

	always @(posedge clk) begin : result_check
		endpoint_rec_t want, got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.x = res_ch.end_x;
			got.y = res_ch.end_y;
			got.code = res_ch.neighbour_code;
			got.line_end = res_ch.is_endpoint;
			got.frame_done = res_ch.frame_done;
			results_seen++;
			if (expected.size() == 0) begin
				note_error({"unexpected result ", fmt_rec(got)});
			end else begin
				want = expected.pop_front();
				if (got !== want)
					note_error({"expected ", fmt_rec(want), ", got ", fmt_rec(got)});
			end
		end
	end

	initial begin : result_taker
		int n;
		bit held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && results_seen >= 20) begin
				held = 1'b1;
				n = LONG_HOLD;
			end else if ($urandom_range(0, 299) == 0) begin
				n = $urandom_range(100, 300);
			end else begin
				n = idle_len(take_calm);
			end
			if (n > 0) begin
				res_ch.ready <= 1'b0;
				repeat (n)
					@(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		bit has_res;
		endpoint_rec_t rec;
		arst_n <= 1'b0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel_value <= '0;
		pix_ch.first_of_frame <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		apb_read(sed_pkg::REG_WIDTH, sed_pkg::WIDTH_RESET);
		apb_read(sed_pkg::REG_HEIGHT, sed_pkg::HEIGHT_RESET);

		// both below the minimum, used as 3x3
		set_dims(13'd0, 13'd1);
		foreach (directed_px[i]) begin
			send_pixel(directed_px[i].value, directed_px[i].first, has_res, rec);
			if (directed_px[i].has_res)
				expected.insert(expected.size(), directed_px[i].want);
		end

		while (pixels_fed < RANDOM_ITEMS)
			run_phase(pick_dim(10, 48), pick_dim(6, 16), $urandom_range(1, 3),
				$urandom_range(2, 6), $urandom_range(0, 3) == 0, 200,
				RANDOM_ITEMS - pixels_fed);

		// widest and tallest register values, clamped to the maximum; frame start only
		run_phase(13'd8191, 13'd3, 1, 4, 1'b0, 0, EDGE_ITEMS);
		run_phase(13'd3, 13'd8191, 1, 4, 1'b0, 0, EDGE_ITEMS);

		pix_ch.valid <= 1'b0;
		while (expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE * 4)
			@(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
